@@ rtl/ltocc_pkg.sv @@
// package for the light, touch and proximity open/close controller: types and constants
`default_nettype none

package ltocc_pkg;

  localparam logic [4:0]  CAL_SAMPLES = 5'd20;
  localparam logic [2:0]  REOPEN_HOLD = 3'd5;
  localparam logic [15:0] FULL_SCALE  = 16'd4095;

  // divide by ten through a reciprocal, exact for dividends below 2^24
  localparam int          DIV10_SHIFT = 27;
  localparam logic [23:0] DIV10_MUL   = 24'd13421773;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_DECIDE  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_OPEN  = 2'd2,
    ACT_CLOSE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CAUSE_NONE        = 3'd0,
    CAUSE_RIGHT_TOUCH = 3'd1,
    CAUSE_LEFT_TOUCH  = 3'd2,
    CAUSE_TOO_CLOSE   = 3'd3,
    CAUSE_TOO_DARK    = 3'd4,
    CAUSE_TOO_BRIGHT  = 3'd5,
    CAUSE_BRIGHT_HELD = 3'd6
  } cause_t;

  typedef enum logic [2:0] {
    REG_INIT_LOW  = 3'd0,
    REG_INIT_HIGH = 3'd1,
    REG_MARGIN    = 3'd2,
    REG_NEAR      = 3'd3,
    REG_NEAR_EN   = 3'd4,
    REG_AUTO      = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        light_present;
    logic        light_status_ok;
    logic [15:0] brightness_raw;
    logic [15:0] distance_raw;
    logic        touch_present;
    logic        touch_a;
    logic        touch_b;
    logic        motor_ready;
  } in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  cause;
    logic        calibrated;
    logic [11:0] ambient_level;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/light_touch_open_close_controller_top.sv @@
// top level of the light, touch and proximity open/close controller
// Usage:
//   in channel (in_valid/in_stall/in_data) carries sample, decide and restart
//   beats; every accepted beat yields exactly one beat on the out channel
//   (out_valid/out_stall/out_data) with action, cause, calibration flag and
//   the integer ambient level after that beat took effect.
//   The result is registered: a beat accepted at a clock edge shows on out_data
//   in the next cycle. Throughput is one beat per cycle while no result is held
//   under out_stall; all state updates, including the 0.9/0.1 ambient average
//   (reciprocal multiply by one tenth) and the threshold clamp, are combinational.
//   The result register is the only buffer: in_stall rises only while a
//   result is held and out_stall is high, so a new beat enters in the same
//   cycle the held result is taken.
//   Configuration writes (cfg_wr_en/cfg_index/cfg_data) land at once and are
//   meant for idle periods; writing the initial thresholds also loads the
//   active thresholds.
//   Synchronous reset (rst_n low) empties the result register, restores the
//   register defaults and starts in the calibrated state with ambient zero.
`default_nettype none

module light_touch_open_close_controller_top (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  ltocc_pkg::in_t   in_data,
  output logic             out_valid,
  input  wire              out_stall,
  output ltocc_pkg::out_t  out_data,
  input  wire              cfg_wr_en,
  input  wire  [2:0]       cfg_index,
  input  wire  [11:0]      cfg_data
);

  // configuration
  logic [11:0] margin_r, near_r;
  logic        near_en_r, auto_r;

  // controller state
  logic [19:0] avg_r, avg_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [11:0] low_thr_r, low_thr_nxt, high_thr_r, high_thr_nxt;
  logic [11:0] bright_r, bright_nxt, close_r, close_nxt;
  logic        left_r, left_nxt, right_r, right_nxt;
  logic        light_ok_r, light_ok_nxt, touch_ok_r, touch_ok_nxt;
  logic [2:0]  hold_r, hold_nxt;

  logic             out_valid_r, out_valid_nxt;
  ltocc_pkg::out_t  out_data_r, res;

  logic                 accept;
  ltocc_pkg::cmd_t      cmd;
  ltocc_pkg::action_t   act;
  ltocc_pkg::cause_t    cause;
  logic                 sample_ok, cal_done;
  logic [23:0]          avg_sum;
  logic [47:0]          avg_prod;
  logic [19:0]          avg_div, avg_upd;
  logic [4:0]           cnt_inc;
  logic [11:0]          amb;
  logic [12:0]          amb_hi;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cmd       = ltocc_pkg::cmd_t'(in_data.command);
  assign cal_done  = (cnt_r >= ltocc_pkg::CAL_SAMPLES);

  assign sample_ok = in_data.light_present && in_data.light_status_ok &&
                     (in_data.brightness_raw <= ltocc_pkg::FULL_SCALE) &&
                     (in_data.distance_raw <= ltocc_pkg::FULL_SCALE);

  // round-to-nearest (9*avg + b*256 + 5) / 10
  assign avg_sum  = {1'b0, avg_r, 3'b000} + {4'b0000, avg_r} +
                    {4'b0000, in_data.brightness_raw[11:0], 8'h00} + 24'd5;
  assign avg_prod = avg_sum * ltocc_pkg::DIV10_MUL;
  assign avg_div  = avg_prod[ltocc_pkg::DIV10_SHIFT +: 20];
  assign cnt_inc  = cnt_r + 5'd1;
  assign avg_upd  = (cnt_r == 5'd0) ? {in_data.brightness_raw[11:0], 8'h00} : avg_div;
  assign amb      = avg_upd[19:8];
  assign amb_hi   = {1'b0, amb} + {1'b0, margin_r};

  always_comb begin
    avg_nxt      = avg_r;
    cnt_nxt      = cnt_r;
    low_thr_nxt  = low_thr_r;
    high_thr_nxt = high_thr_r;
    bright_nxt   = bright_r;
    close_nxt    = close_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    light_ok_nxt = light_ok_r;
    touch_ok_nxt = touch_ok_r;
    hold_nxt     = hold_r;
    act          = ltocc_pkg::ACT_NONE;
    cause        = ltocc_pkg::CAUSE_NONE;
    if (accept) begin
      case (cmd)
        ltocc_pkg::CMD_SAMPLE: begin
          light_ok_nxt = in_data.light_present;
          if (sample_ok) begin
            bright_nxt = in_data.brightness_raw[11:0];
            close_nxt  = 12'(ltocc_pkg::FULL_SCALE - in_data.distance_raw);
            if (!cal_done) begin
              cnt_nxt = cnt_inc;
              avg_nxt = avg_upd;
              if (cnt_inc == ltocc_pkg::CAL_SAMPLES) begin
                low_thr_nxt  = (amb > margin_r) ? amb - margin_r : 12'd0;
                high_thr_nxt = (amb_hi > 13'(ltocc_pkg::FULL_SCALE)) ?
                               12'(ltocc_pkg::FULL_SCALE) : amb_hi[11:0];
              end
            end
          end
          touch_ok_nxt = in_data.touch_present;
          left_nxt     = in_data.touch_present && in_data.touch_a;
          right_nxt    = in_data.touch_present && in_data.touch_b;
        end
        ltocc_pkg::CMD_DECIDE: begin
          if (in_data.motor_ready && auto_r) begin
            if (touch_ok_r && right_r) begin
              act      = ltocc_pkg::ACT_OPEN;
              cause    = ltocc_pkg::CAUSE_RIGHT_TOUCH;
              hold_nxt = ltocc_pkg::REOPEN_HOLD;
            end else if (touch_ok_r && left_r) begin
              act      = ltocc_pkg::ACT_CLOSE;
              cause    = ltocc_pkg::CAUSE_LEFT_TOUCH;
              hold_nxt = ltocc_pkg::REOPEN_HOLD;
            end else begin
              act = ltocc_pkg::ACT_STOP;
              if (light_ok_r && cal_done) begin
                if (near_en_r && (near_r > close_r)) begin
                  act      = ltocc_pkg::ACT_CLOSE;
                  cause    = ltocc_pkg::CAUSE_TOO_CLOSE;
                  hold_nxt = ltocc_pkg::REOPEN_HOLD;
                end else if (low_thr_r > bright_r) begin
                  act      = ltocc_pkg::ACT_CLOSE;
                  cause    = ltocc_pkg::CAUSE_TOO_DARK;
                  hold_nxt = ltocc_pkg::REOPEN_HOLD;
                end else if (high_thr_r < bright_r) begin
                  if (hold_r == 3'd0) begin
                    act   = ltocc_pkg::ACT_OPEN;
                    cause = ltocc_pkg::CAUSE_TOO_BRIGHT;
                  end else begin
                    hold_nxt = hold_r - 3'd1;
                    cause    = ltocc_pkg::CAUSE_BRIGHT_HELD;
                  end
                end
              end
            end
          end
        end
        ltocc_pkg::CMD_RESTART: begin
          cnt_nxt = 5'd0;
        end
        default: begin
        end
      endcase
    end
    // initial threshold writes go straight into the active thresholds
    if (cfg_wr_en) begin
      if (cfg_index == ltocc_pkg::REG_INIT_LOW) begin
        low_thr_nxt = cfg_data;
      end
      if (cfg_index == ltocc_pkg::REG_INIT_HIGH) begin
        high_thr_nxt = cfg_data;
      end
    end
  end

  always_comb begin
    res.action        = act;
    res.cause         = cause;
    res.calibrated    = (cnt_nxt >= ltocc_pkg::CAL_SAMPLES);
    res.ambient_level = avg_nxt[19:8];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      margin_r    <= 12'd410;
      near_r      <= 12'd2048;
      near_en_r   <= 1'b0;
      auto_r      <= 1'b1;
      avg_r       <= 20'd0;
      cnt_r       <= ltocc_pkg::CAL_SAMPLES;
      low_thr_r   <= 12'd1024;
      high_thr_r  <= 12'd3072;
      bright_r    <= 12'd0;
      close_r     <= 12'd0;
      left_r      <= 1'b0;
      right_r     <= 1'b0;
      light_ok_r  <= 1'b0;
      touch_ok_r  <= 1'b0;
      hold_r      <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      avg_r       <= avg_nxt;
      cnt_r       <= cnt_nxt;
      bright_r    <= bright_nxt;
      close_r     <= close_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      light_ok_r  <= light_ok_nxt;
      touch_ok_r  <= touch_ok_nxt;
      hold_r      <= hold_nxt;
      low_thr_r   <= low_thr_nxt;
      high_thr_r  <= high_thr_nxt;
      if (cfg_wr_en) begin
        case (ltocc_pkg::reg_index_t'(cfg_index))
          ltocc_pkg::REG_MARGIN:  margin_r  <= cfg_data;
          ltocc_pkg::REG_NEAR:    near_r    <= cfg_data;
          ltocc_pkg::REG_NEAR_EN: near_en_r <= cfg_data[0];
          ltocc_pkg::REG_AUTO:    auto_r    <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result held");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ltocc_pkg::CAL_SAMPLES)
    else $error("calibration count overran");

  a_hold_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r <= ltocc_pkg::REOPEN_HOLD)
    else $error("reopen hold overran");

  a_sample_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.command != ltocc_pkg::CMD_DECIDE) |=>
      (out_data_r.action == ltocc_pkg::ACT_NONE) &&
      (out_data_r.cause == ltocc_pkg::CAUSE_NONE))
    else $error("non-decide beat produced an action");

  a_manual_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.command == ltocc_pkg::CMD_DECIDE) && !auto_r |=>
      out_data_r.action == ltocc_pkg::ACT_NONE)
    else $error("decide acted while not autonomous");

  a_calibrated_flag: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_data_r.calibrated == (cnt_r >= ltocc_pkg::CAL_SAMPLES))
    else $error("calibrated flag disagrees with sample count");

endmodule

`default_nettype wire
